@@ design/utf8_byte_to_codepoint_range_defines.svh @@
// Assertion macros used by the checker file.
`ifndef UTF8_BYTE_TO_CODEPOINT_RANGE_DEFINES_SVH
`define UTF8_BYTE_TO_CODEPOINT_RANGE_DEFINES_SVH

// Clocked property, skipped while reset is high.
`define UTF8CP_ASSERT(label, ck, rs, prop) \
  label: assert property (@(posedge ck) disable iff (rs) (prop)) \
    else $error("utf8cp check failed");

// Clocked implication, skipped while reset is high.
`define UTF8CP_ASSERT_IMP(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("utf8cp implication failed");

`endif

@@ design/utf8cp_pkg.sv @@
package utf8cp_pkg;

  localparam int OFFSET_W = 17;
  localparam int CP_W     = 17;

  // Configuration register indexes
  localparam logic REG_START_OFFSET = 1'b0;
  localparam logic REG_END_OFFSET   = 1'b1;

  // Range rule for the next continuation byte
  typedef enum logic [2:0] {
    CLS_ANY   = 3'd0,
    CLS_A0_BF = 3'd1,
    CLS_80_9F = 3'd2,
    CLS_90_BF = 3'd3,
    CLS_80_8F = 3'd4
  } second_class_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic            success;
    logic [CP_W-1:0] codepoint_start;
    logic [CP_W-1:0] codepoint_end;
  } out_item_t;

  // Scan state carried from byte to byte
  typedef struct packed {
    logic [CP_W-1:0] codepoint_count;
    logic [1:0]      continuations_left;
    second_class_t   second_byte_class;
    logic [CP_W-1:0] start_codepoint;
    logic            start_seen;
    logic            scan_failed;
  } scan_t;

  // Where the current byte sits relative to the limit and offsets
  typedef struct packed {
    logic pos_full;
    logic in_range;
    logic at_start;
    logic at_end;
  } pos_flags_t;

endpackage

@@ design/utf8cp_channels.sv @@
interface utf8cp_in_if;
  import utf8cp_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface utf8cp_out_if;
  import utf8cp_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

@@ design/utf8cp_step.sv @@
module utf8cp_step (
  input  utf8cp_pkg::scan_t      cur,
  input  logic [7:0]             text_byte,
  input  utf8cp_pkg::pos_flags_t flags,
  output utf8cp_pkg::scan_t      nxt
);
  import utf8cp_pkg::*;

  function automatic logic cont_ok(input logic [7:0] b, input second_class_t cls);
    case (cls)
      CLS_A0_BF: cont_ok = (b >= 8'hA0) && (b <= 8'hBF);
      CLS_80_9F: cont_ok = (b >= 8'h80) && (b <= 8'h9F);
      CLS_90_BF: cont_ok = (b >= 8'h90) && (b <= 8'hBF);
      CLS_80_8F: cont_ok = (b >= 8'h80) && (b <= 8'h8F);
      default:   cont_ok = (b & 8'hC0) == 8'h80;
    endcase
  endfunction

  // Advance the scan by one byte
  always_comb begin
    nxt = cur;
    if (!cur.scan_failed) begin
      if (flags.pos_full) begin
        nxt.scan_failed = 1'b1;
      end else if (flags.in_range) begin
        if (cur.continuations_left == 2'd0) begin
          // Byte on a sequence boundary: capture start, decode the lead
          if (flags.at_start) begin
            nxt.start_codepoint = cur.codepoint_count;
            nxt.start_seen      = 1'b1;
          end
          nxt.second_byte_class = CLS_ANY;
          if (text_byte[7] == 1'b0) begin
            nxt.codepoint_count    = cur.codepoint_count + 17'd1;
            nxt.continuations_left = 2'd0;
          end else if (text_byte >= 8'hC2 && text_byte <= 8'hDF) begin
            nxt.continuations_left = 2'd1;
          end else if (text_byte == 8'hE0) begin
            nxt.continuations_left = 2'd2;
            nxt.second_byte_class  = CLS_A0_BF;
          end else if (text_byte == 8'hED) begin
            nxt.continuations_left = 2'd2;
            nxt.second_byte_class  = CLS_80_9F;
          end else if (text_byte >= 8'hE1 && text_byte <= 8'hEF) begin
            nxt.continuations_left = 2'd2;
          end else if (text_byte == 8'hF0) begin
            nxt.continuations_left = 2'd3;
            nxt.second_byte_class  = CLS_90_BF;
          end else if (text_byte == 8'hF4) begin
            nxt.continuations_left = 2'd3;
            nxt.second_byte_class  = CLS_80_8F;
          end else if (text_byte >= 8'hF1 && text_byte <= 8'hF3) begin
            nxt.continuations_left = 2'd3;
          end else begin
            nxt.scan_failed = 1'b1;
          end
        end else if (flags.at_start || !cont_ok(text_byte, cur.second_byte_class)) begin
          nxt.scan_failed = 1'b1;
        end else begin
          // Continuation byte accepted
          nxt.second_byte_class  = CLS_ANY;
          nxt.continuations_left = cur.continuations_left - 2'd1;
          if (cur.continuations_left == 2'd1) begin
            nxt.codepoint_count = cur.codepoint_count + 17'd1;
          end
        end
      end else if (flags.at_end && cur.continuations_left != 2'd0) begin
        nxt.scan_failed = 1'b1;
      end
    end
  end

endmodule

@@ design/utf8_byte_to_codepoint_range.sv @@
// The byte marked last passes the input register, then its result is registered.
// One byte per cycle unless a last byte waits; texts may follow back to back.
// The per-byte scan state lives in one register set updated from the input register.
// The result register decouples the output; a stalled result does not block bytes
// that are not the last of a text. Synchronous active-high reset clears the scan
// state, the pipeline valids and both offset registers.
module utf8_byte_to_codepoint_range #(
  parameter int MAX_TEXT_BYTES = 65536
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [utf8cp_pkg::OFFSET_W-1:0] cfg_data,
  utf8cp_in_if.sink                       in_ch,
  utf8cp_out_if.source                    out_ch
);
  import utf8cp_pkg::*;

  localparam int POS_W = $clog2(MAX_TEXT_BYTES + 1);
  localparam int CMP_W = (POS_W > OFFSET_W) ? POS_W : OFFSET_W;

  logic [OFFSET_W-1:0] start_offset;
  logic [OFFSET_W-1:0] end_offset;

  logic                s1_valid;
  in_item_t            s1_item;
  logic                s1_adv;
  logic                out_free;
  logic                in_fire;

  logic [POS_W-1:0]    byte_position;
  logic [POS_W-1:0]    byte_position_next;
  scan_t               scan;
  scan_t               scan_next;
  pos_flags_t          flags;

  logic [CMP_W-1:0]    pos_ext;
  logic [CMP_W-1:0]    pos_next_ext;
  logic [CMP_W-1:0]    start_ext;
  logic [CMP_W-1:0]    end_ext;

  out_item_t           result;
  logic                out_valid;
  out_item_t           out_data;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      start_offset <= '0;
      end_offset   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START_OFFSET: start_offset <= cfg_data;
        REG_END_OFFSET:   end_offset   <= cfg_data;
        default:          ;
      endcase
    end
  end

  // Handshake: only a last byte waits for the result register
  assign out_free    = !out_valid || out_ch.ready;
  assign s1_adv      = s1_valid && (!s1_item.last_byte || out_free);
  assign in_ch.ready = !s1_valid || s1_adv;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_fire || (s1_valid && !s1_adv);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item <= in_ch.data;
    end
  end

  // Position flags
  assign pos_ext      = CMP_W'(byte_position);
  assign start_ext    = CMP_W'(start_offset);
  assign end_ext      = CMP_W'(end_offset);

  assign flags.pos_full = byte_position >= POS_W'(MAX_TEXT_BYTES);
  assign flags.in_range = pos_ext < end_ext;
  assign flags.at_start = pos_ext == start_ext;
  assign flags.at_end   = pos_ext == end_ext;

  assign byte_position_next = (!scan.scan_failed && !flags.pos_full) ?
                              byte_position + POS_W'(1) : byte_position;
  assign pos_next_ext = CMP_W'(byte_position_next);

  utf8cp_step u_step (
    .cur       (scan),
    .text_byte (s1_item.text_byte),
    .flags     (flags),
    .nxt       (scan_next)
  );

  // Result from the state after this byte
  always_comb begin
    logic ok;
    ok = !scan_next.scan_failed && (start_offset <= end_offset) &&
         (end_ext <= pos_next_ext) && (scan_next.continuations_left == 2'd0);
    result.codepoint_start = '0;
    result.codepoint_end   = '0;
    if (ok) begin
      if (start_offset == end_offset) begin
        result.codepoint_start = scan_next.codepoint_count;
      end else if (scan_next.start_seen) begin
        result.codepoint_start = scan_next.start_codepoint;
      end else begin
        ok = 1'b0;
      end
    end
    if (ok) begin
      result.codepoint_end = scan_next.codepoint_count;
    end else begin
      result.codepoint_start = '0;
    end
    result.success = ok;
  end

  // Scan state: advance per byte, clear after the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      scan          <= '0;
    end else if (s1_adv) begin
      if (s1_item.last_byte) begin
        byte_position <= '0;
        scan          <= '0;
      end else begin
        byte_position <= byte_position_next;
        scan          <= scan_next;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && s1_item.last_byte) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_item.last_byte) begin
      out_data <= result;
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data;

endmodule

@@ design/utf8cp_checker.sv @@
`include "utf8_byte_to_codepoint_range_defines.svh"

module utf8cp_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        in_last,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_success,
  input logic [utf8cp_pkg::CP_W-1:0] out_cp_start,
  input logic [utf8cp_pkg::CP_W-1:0] out_cp_end
);
  import utf8cp_pkg::*;

  // Hold a stalled result
  `UTF8CP_ASSERT_IMP(a_out_hold, clk, rst, out_valid && !out_ready,
    ##1 (out_valid && $stable(out_success) && $stable(out_cp_start) && $stable(out_cp_end)))

  // A failed result reports zero indices
  `UTF8CP_ASSERT(a_fail_zero, clk, rst,
    !(out_valid && !out_success) || (out_cp_start == '0 && out_cp_end == '0))

  // The start index never passes the end index
  `UTF8CP_ASSERT(a_order, clk, rst, !(out_valid && out_success) || out_cp_start <= out_cp_end)

  // A fresh result follows the transfer of a last byte
  `UTF8CP_ASSERT_IMP(a_result_cause, clk, rst, $rose(out_valid),
    $past(in_valid && in_ready && in_last, 2))

endmodule

bind utf8_byte_to_codepoint_range utf8cp_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .in_last      (in_ch.data.last_byte),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_success  (out_ch.data.success),
  .out_cp_start (out_ch.data.codepoint_start),
  .out_cp_end   (out_ch.data.codepoint_end)
);

@@ bench/utf8_byte_to_codepoint_range_test.sv @@
module utf8_byte_to_codepoint_range_test;
  timeunit 1ns;
  timeprecision 1ps;

  import utf8cp_pkg::*;

  localparam int TEXT_LIMIT   = 65536;
  localparam int RANDOM_ITEMS = 550;
  localparam int CYCLE_LIMIT  = 100_000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 300;

  // Predicts the code point range of each text and checks the block's answers
  class codepoint_range_scoreboard;
    logic [OFFSET_W-1:0] range_start;
    logic [OFFSET_W-1:0] range_end;
    logic [OFFSET_W-1:0] byte_pos;
    logic [CP_W-1:0]     cp_count;
    logic [CP_W-1:0]     cp_at_start;
    logic [1:0]          conts_left;
    second_class_t       next_class;
    bit                  start_hit;
    bit                  text_bad;
    out_item_t           pending_ranges[$];
    int                  mismatches;

    function new();
      range_start = '0;
      range_end   = '0;
      mismatches  = 0;
      clear_text();
    endfunction

    function void set_range(logic [OFFSET_W-1:0] s, logic [OFFSET_W-1:0] e);
      range_start = s;
      range_end   = e;
    endfunction

    function void clear_text();
      byte_pos    = '0;
      cp_count    = '0;
      cp_at_start = '0;
      conts_left  = '0;
      next_class  = CLS_ANY;
      start_hit   = 1'b0;
      text_bad    = 1'b0;
    endfunction

    function int outstanding();
      return pending_ranges.size();
    endfunction

    function bit cont_fits(logic [7:0] b);
      case (next_class)
        CLS_A0_BF: return b >= 8'hA0 && b <= 8'hBF;
        CLS_80_9F: return b >= 8'h80 && b <= 8'h9F;
        CLS_90_BF: return b >= 8'h90 && b <= 8'hBF;
        CLS_80_8F: return b >= 8'h80 && b <= 8'h8F;
        default:   return b[7:6] == 2'b10;
      endcase
    endfunction

    // Decode a lead byte into the number of trailing bytes and the rule for the next one
    function void take_lead(logic [7:0] b);
      next_class = CLS_ANY;
      if (!b[7]) begin
        cp_count++;
        conts_left = 2'd0;
      end else if (b >= 8'hC2 && b <= 8'hDF) begin
        conts_left = 2'd1;
      end else if (b == 8'hE0) begin
        conts_left = 2'd2;
        next_class = CLS_A0_BF;
      end else if (b == 8'hED) begin
        conts_left = 2'd2;
        next_class = CLS_80_9F;
      end else if (b >= 8'hE1 && b <= 8'hEF) begin
        conts_left = 2'd2;
      end else if (b == 8'hF0) begin
        conts_left = 2'd3;
        next_class = CLS_90_BF;
      end else if (b == 8'hF4) begin
        conts_left = 2'd3;
        next_class = CLS_80_8F;
      end else if (b >= 8'hF1 && b <= 8'hF3) begin
        conts_left = 2'd3;
      end else begin
        text_bad = 1'b1;
      end
    endfunction

    // Advance the scan by one accepted byte; queue the range on the last byte
    function void take_text_byte(logic [7:0] b, logic last);
      out_item_t r;
      bit        ok;
      if (!text_bad) begin
        if (byte_pos >= TEXT_LIMIT) begin
          text_bad = 1'b1;
        end else begin
          if (byte_pos < range_end) begin
            if (conts_left == 0) begin
              if (byte_pos == range_start) begin
                cp_at_start = cp_count;
                start_hit   = 1'b1;
              end
              take_lead(b);
            end else if (byte_pos == range_start || !cont_fits(b)) begin
              text_bad = 1'b1;
            end else begin
              next_class = CLS_ANY;
              conts_left--;
              if (conts_left == 0) cp_count++;
            end
          end else if (byte_pos == range_end && conts_left != 0) begin
            text_bad = 1'b1;
          end
          byte_pos++;
        end
      end
      if (!last) return;
      r  = '0;
      ok = !text_bad && range_start <= range_end && range_end <= byte_pos &&
           conts_left == 0;
      if (ok) begin
        r.codepoint_end = cp_count;
        if (range_start == range_end) r.codepoint_start = cp_count;
        else if (start_hit) r.codepoint_start = cp_at_start;
        else ok = 1'b0;
      end
      if (!ok) r = '0;
      r.success = ok;
      pending_ranges.push_back(r);
      clear_text();
    endfunction

    task note_mismatch(string what, int want_v, int got_v);
      $display("mismatch in %s: expected %0d, got %0d", what, want_v, got_v);
      mismatches++;
    endtask

    task check_range_result(out_item_t got);
      out_item_t want;
      if (pending_ranges.size() == 0) begin
        note_mismatch("result with no text pending", 0, got.success);
        return;
      end
      want = pending_ranges.pop_front();
      if (got.success !== want.success)
        note_mismatch("success", want.success, got.success);
      if (got.codepoint_start !== want.codepoint_start)
        note_mismatch("codepoint_start", want.codepoint_start, got.codepoint_start);
      if (got.codepoint_end !== want.codepoint_end)
        note_mismatch("codepoint_end", want.codepoint_end, got.codepoint_end);
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_we;
  logic                cfg_index;
  logic [OFFSET_W-1:0] cfg_data;

  utf8cp_in_if  in_ch();
  utf8cp_out_if out_ch();

  codepoint_range_scoreboard sb = new();

  logic [7:0] text_bytes[$];
  int         burst_left  = 0;
  bit         hold_off_req = 1'b0;
  int         items_sent  = 0;
  int         cycle_count = 0;

  utf8_byte_to_codepoint_range #(
    .MAX_TEXT_BYTES(TEXT_LIMIT)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  always #6 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic [7:0] tail_byte();
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  // Append one random code point, now and then a broken or truncated one
  function automatic void add_codepoint();
    int         kind;
    logic [7:0] lead;
    kind = $urandom_range(0, 19);
    case (kind)
      0, 1, 2, 3, 4, 5, 6: text_bytes.push_back(8'($urandom_range(0, 127)));
      7, 18: begin
        text_bytes.push_back(8'($urandom_range(8'hC2, 8'hDF)));
        text_bytes.push_back(tail_byte());
      end
      8: begin
        text_bytes.push_back(8'hE0);
        text_bytes.push_back(8'($urandom_range(8'hA0, 8'hBF)));
        text_bytes.push_back(tail_byte());
      end
      9: begin
        text_bytes.push_back(8'hED);
        text_bytes.push_back(8'($urandom_range(8'h80, 8'h9F)));
        text_bytes.push_back(tail_byte());
      end
      10, 11: begin
        lead = 8'($urandom_range(8'hE1, 8'hEF));
        if (lead == 8'hED) lead = 8'hEE;
        text_bytes.push_back(lead);
        text_bytes.push_back(tail_byte());
        text_bytes.push_back(tail_byte());
      end
      12: begin
        text_bytes.push_back(8'hF0);
        text_bytes.push_back(8'($urandom_range(8'h90, 8'hBF)));
        text_bytes.push_back(tail_byte());
        text_bytes.push_back(tail_byte());
      end
      13: begin
        text_bytes.push_back(8'($urandom_range(8'hF1, 8'hF3)));
        repeat (3) text_bytes.push_back(tail_byte());
      end
      14: begin
        text_bytes.push_back(8'hF4);
        text_bytes.push_back(8'($urandom_range(8'h80, 8'h8F)));
        text_bytes.push_back(tail_byte());
        text_bytes.push_back(tail_byte());
      end
      15: begin
        // restricted lead followed by a second byte outside its window
        case ($urandom_range(0, 3))
          0: begin
            text_bytes.push_back(8'hE0);
            text_bytes.push_back(8'($urandom_range(8'h80, 8'h9F)));
          end
          1: begin
            text_bytes.push_back(8'hED);
            text_bytes.push_back(8'($urandom_range(8'hA0, 8'hBF)));
          end
          2: begin
            text_bytes.push_back(8'hF0);
            text_bytes.push_back(8'($urandom_range(8'h80, 8'h8F)));
          end
          default: begin
            text_bytes.push_back(8'hF4);
            text_bytes.push_back(8'($urandom_range(8'h90, 8'hBF)));
          end
        endcase
        text_bytes.push_back(tail_byte());
      end
      16: text_bytes.push_back(8'($urandom_range(0, 255)));
      17: begin
        // three-byte sequence cut short
        text_bytes.push_back(8'($urandom_range(8'hE1, 8'hEC)));
        text_bytes.push_back(tail_byte());
      end
      default: begin
        case ($urandom_range(0, 2))
          0:       text_bytes.push_back(8'($urandom_range(8'hF5, 8'hFF)));
          1:       text_bytes.push_back(8'hC0 | 8'($urandom_range(0, 1)));
          default: text_bytes.push_back(tail_byte());
        endcase
      end
    endcase
  endfunction

  // Offer one byte, idling between bursts, and hold it until the transfer
  task automatic send_byte(input logic [7:0] b, input logic last);
    in_item_t item;
    int       gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    item.text_byte = b;
    item.last_byte = last;
    in_ch.valid <= 1'b1;
    in_ch.data  <= item;
    do @(posedge clk); while (!in_ch.ready);
    sb.take_text_byte(b, last);
    if (burst_left > 0) burst_left--;
    items_sent++;
  endtask

  task automatic send_text();
    int n;
    n = text_bytes.size();
    for (int i = 0; i < n; i++) send_byte(text_bytes[i], i == n - 1);
  endtask

  // Drop valid and wait until every range has come back and the pipe is empty
  task automatic finish_phase();
    in_ch.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_range(input logic [OFFSET_W-1:0] s, input logic [OFFSET_W-1:0] e);
    cfg_we    <= 1'b1;
    cfg_index <= REG_START_OFFSET;
    cfg_data  <= s;
    @(posedge clk);
    cfg_index <= REG_END_OFFSET;
    cfg_data  <= e;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_range(s, e);
  endtask

  task automatic random_phase(input int texts, input int max_end);
    logic [OFFSET_W-1:0] s;
    logic [OFFSET_W-1:0] e;
    int                  pick;
    int                  target;
    e    = OFFSET_W'($urandom_range(0, max_end));
    pick = $urandom_range(0, 19);
    if (pick < 11) s = OFFSET_W'($urandom_range(0, e));
    else if (pick < 14) s = e;
    else if (pick < 16) s = e + OFFSET_W'($urandom_range(1, 4));
    else s = OFFSET_W'($urandom_range(0, max_end + 4));
    set_range(s, e);
    repeat (texts) begin
      text_bytes.delete();
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 10)) text_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
        target = ($urandom_range(0, 6) == 0) ? $urandom_range(1, e + 1)
                                             : e + $urandom_range(1, 6);
        while (text_bytes.size() < target) add_codepoint();
      end
      send_text();
    end
    finish_phase();
  endtask

  // Short texts against a long receiver hold so results back up into the input
  task automatic pressure_phase();
    int target;
    set_range(OFFSET_W'($urandom_range(0, 1)), OFFSET_W'($urandom_range(1, 2)));
    hold_off_req = 1'b1;
    repeat (24) begin
      text_bytes.delete();
      target = $urandom_range(1, 3);
      while (text_bytes.size() < target) add_codepoint();
      send_text();
    end
    finish_phase();
  endtask

  // Receiver: check each result, then pick ready from the current stall pattern
  initial begin : result_sink
    int hold_left;
    int mode;
    int mode_left;
    int stall_left;
    bit rdy;
    hold_left  = 0;
    mode       = 0;
    mode_left  = 0;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_ch.valid && out_ch.ready) sb.check_range_result(out_ch.data);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 80);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        case (mode)
          0: rdy = 1'b1;
          1: rdy = 1'($urandom_range(0, 1));
          default: begin
            if (stall_left > 0) begin
              stall_left--;
              rdy = 1'b0;
            end else begin
              rdy = 1'b1;
              if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 15);
            end
          end
        endcase
      end
      out_ch.ready <= rdy;
    end
  end

  initial begin : stimulus
    int phase;
    rst         <= 1'b1;
    cfg_we      <= 1'b0;
    cfg_index   <= REG_START_OFFSET;
    cfg_data    <= '0;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // End offset zero: nothing is scanned
    set_range(0, 0);
    text_bytes = '{8'h00};
    send_text();
    text_bytes = '{8'hFF, 8'h80};
    send_text();
    finish_phase();

    // Clean range, restricted second byte, start inside a sequence, short text
    set_range(1, 4);
    text_bytes = '{8'h41, 8'hE0, 8'hA0, 8'h80, 8'hFF};
    send_text();
    text_bytes = '{8'h41, 8'hED, 8'hA0, 8'h80};
    send_text();
    text_bytes = '{8'hC3, 8'hA9, 8'hF4, 8'h90};
    send_text();
    text_bytes = '{8'h41, 8'h42};
    send_text();
    finish_phase();

    // Start after end
    set_range(5, 3);
    text_bytes = '{8'h41, 8'h7F, 8'h41};
    send_text();
    finish_phase();

    // Start equal to end, lead byte sitting at the end offset
    set_range(2, 2);
    text_bytes = '{8'h41, 8'h7F, 8'hC2, 8'h80};
    send_text();
    finish_phase();

    // Four-byte sequence, then a truncated sequence inside the range
    set_range(0, 4);
    text_bytes = '{8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'h41};
    send_text();
    text_bytes = '{8'hE1, 8'h80, 8'h41, 8'h41};
    send_text();
    finish_phase();

    // Random phases, one of them under receiver pressure
    items_sent = 0;
    phase      = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if (phase == 2) pressure_phase();
      else random_phase($urandom_range(2, 6), (phase % 4 == 0) ? 4 : 24);
      phase++;
    end

    if (sb.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
